// ===== rtl/atau_pkg.sv =====
// Shared types, constants and fixed-point helpers for the affine transform
// accumulator. Used by every module in rtl/; depends on nothing.
package atau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CELLS     = 16;
    localparam int CELL_W    = 32;
    localparam int IDX_W     = 4;
    localparam int WIDE_W    = 64;

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef cell_t matrix_t [CELLS];
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        FUNC_IDENTITY  = 3'd0,
        FUNC_TRANSLATE = 3'd1,
        FUNC_SCALE     = 3'd2,
        FUNC_ROT_X     = 3'd3,
        FUNC_ROT_Y     = 3'd4,
        FUNC_ROT_Z     = 3'd5,
        FUNC_READ      = 3'd6
    } func_t;

    typedef struct packed {
        logic busy;
        logic finishing;
    } rd_status_t;

    localparam cell_t ONE     = cell_t'(wide_t'(1) <<< FRAC_BITS);
    localparam idx_t  LAST_IX = idx_t'(CELLS - 1);

    localparam wide_t SAT_MAX = wide_t'(64'sd2147483647);
    localparam wide_t SAT_MIN = -wide_t'(64'sd2147483648);

    // exact product, floored by the fraction width
    function automatic wide_t fx_mul(input cell_t x, input cell_t y);
        wide_t p;
        p = wide_t'(x) * wide_t'(y);
        return p >>> FRAC_BITS;
    endfunction

    function automatic cell_t sat32(input wide_t v);
        cell_t r;
        if (v > SAT_MAX)
            r = cell_t'(SAT_MAX);
        else if (v < SAT_MIN)
            r = cell_t'(SAT_MIN);
        else
            r = cell_t'(v);
        return r;
    endfunction

    function automatic cell_t ident_cell(input int k);
        return (k % 5 == 0) ? ONE : '0;
    endfunction

endpackage

// ===== rtl/affine_transform_accumulator_unit.sv =====
// Top level of the affine transform accumulator: command stage, matrix
// lanes and read-out streamer. Depends on atau_pkg, atau_matrix, atau_readout.
//
//   channel  direction  handshake                payload
//   cmd      in         cmd_valid / cmd_stall    func, operand_a, operand_b, operand_c
//   cell     out        cell_valid / cell_stall  cell_index, cell_value, last_cell
//
// One command per cycle unless cmd_stall is raised: each command is registered in the
// command register, and the matrix register then takes its result from there.
// A read copies the matrix and streams 16 cells, one per accepted cycle; the
// streamer holds one read, so a second read waits until the last cell is taken.
// Transform commands keep flowing while cells are streamed, unless a read waits in the command register.
// Reset loads the identity matrix and empties both stages.
module affine_transform_accumulator_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  logic [2:0]             func,
    input  logic signed [31:0]     operand_a,
    input  logic signed [31:0]     operand_b,
    input  logic signed [31:0]     operand_c,
    output logic                   cell_valid,
    input  logic                   cell_stall,
    output logic [3:0]             cell_index,
    output logic signed [31:0]     cell_value,
    output logic                   last_cell
);

    logic                 stage_valid_reg;
    atau_pkg::func_t      func_reg;
    atau_pkg::cell_t      opa_reg;
    atau_pkg::cell_t      opb_reg;
    atau_pkg::cell_t      opc_reg;
    logic                 blocked;
    logic                 fire;
    logic                 rd_start;
    atau_pkg::matrix_t    cells;
    atau_pkg::rd_status_t rd_status;

    assign blocked   = stage_valid_reg && (func_reg == atau_pkg::FUNC_READ)
                       && rd_status.busy && !rd_status.finishing;
    assign fire      = stage_valid_reg && !blocked;
    assign rd_start  = fire && (func_reg == atau_pkg::FUNC_READ);
    assign cmd_stall = blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (!blocked)
            stage_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !blocked)
        begin
            func_reg <= atau_pkg::func_t'(func);
            opa_reg  <= operand_a;
            opb_reg  <= operand_b;
            opc_reg  <= operand_c;
        end
    end

    atau_matrix u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (fire),
        .func   (func_reg),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .opc    (opc_reg),
        .cells  (cells)
    );

    atau_readout u_readout (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (rd_start),
        .cells      (cells),
        .cell_stall (cell_stall),
        .cell_valid (cell_valid),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .last_cell  (last_cell),
        .status     (rd_status)
    );

    // stall only comes from a read waiting on the streamer
    a_stall_needs_stream: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cell_valid)
        else $error("command stalled while no read out is in progress");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall && !last_cell) |=>
            (cell_valid && cell_index == 4'($past(cell_index) + 4'd1)))
        else $error("read out skipped or repeated a cell");

    a_next_read_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall && last_cell) |=> (!cell_valid || cell_index == 4'd0))
        else $error("new read out did not start at cell zero");

endmodule

// ===== rtl/atau_matrix.sv =====
// Matrix register and the per-row update lanes for all transform commands.
// Depends on atau_pkg.
module atau_matrix (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   update,
    input  atau_pkg::func_t        func,
    input  atau_pkg::cell_t        opa,
    input  atau_pkg::cell_t        opb,
    input  atau_pkg::cell_t        opc,
    output atau_pkg::matrix_t      cells
);

    atau_pkg::matrix_t cells_reg;
    atau_pkg::matrix_t cells_next;

    always_comb
    begin
        cells_next = cells_reg;
        case (func)
            atau_pkg::FUNC_IDENTITY:
            begin
                for (int k = 0; k < atau_pkg::CELLS; k++)
                    cells_next[k] = atau_pkg::ident_cell(k);
            end
            atau_pkg::FUNC_TRANSLATE:
            begin
                for (int r = 0; r < 4; r++)
                    cells_next[12+r] = atau_pkg::sat32(
                        atau_pkg::fx_mul(opa, cells_reg[r])
                        + atau_pkg::fx_mul(opb, cells_reg[4+r])
                        + atau_pkg::fx_mul(opc, cells_reg[8+r])
                        + atau_pkg::wide_t'(cells_reg[12+r]));
            end
            atau_pkg::FUNC_SCALE:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    cells_next[r]   = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[r]));
                    cells_next[4+r] = atau_pkg::sat32(atau_pkg::fx_mul(opb, cells_reg[4+r]));
                    cells_next[8+r] = atau_pkg::sat32(atau_pkg::fx_mul(opc, cells_reg[8+r]));
                end
            end
            atau_pkg::FUNC_ROT_X:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    cells_next[4+r] = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[4+r])
                                    + atau_pkg::fx_mul(opb, cells_reg[8+r]));
                    cells_next[8+r] = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[8+r])
                                    - atau_pkg::fx_mul(opb, cells_reg[4+r]));
                end
            end
            atau_pkg::FUNC_ROT_Y:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    cells_next[8+r] = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[8+r])
                                    + atau_pkg::fx_mul(opb, cells_reg[r]));
                    cells_next[r]   = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[r])
                                    - atau_pkg::fx_mul(opb, cells_reg[8+r]));
                end
            end
            atau_pkg::FUNC_ROT_Z:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    cells_next[r]   = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[r])
                                    + atau_pkg::fx_mul(opb, cells_reg[4+r]));
                    cells_next[4+r] = atau_pkg::sat32(atau_pkg::fx_mul(opa, cells_reg[4+r])
                                    - atau_pkg::fx_mul(opb, cells_reg[r]));
                end
            end
            default:
            begin
                cells_next = cells_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < atau_pkg::CELLS; k++)
                cells_reg[k] <= atau_pkg::ident_cell(k);
        end
        else if (update)
        begin
            cells_reg <= cells_next;
        end
    end

    assign cells = cells_reg;

endmodule

// ===== rtl/atau_readout.sv =====
// Read-out snapshot and cell streamer: copies the matrix on a read command
// and emits the sixteen cells in index order. Depends on atau_pkg.
module atau_readout (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  atau_pkg::matrix_t       cells,
    input  logic                    cell_stall,
    output logic                    cell_valid,
    output atau_pkg::idx_t          cell_index,
    output atau_pkg::cell_t         cell_value,
    output logic                    last_cell,
    output atau_pkg::rd_status_t    status
);

    atau_pkg::matrix_t snap_reg;
    logic              busy_reg;
    atau_pkg::idx_t    cnt_reg;
    logic              taken;

    assign taken = busy_reg && !cell_stall;

    always_ff @(posedge clk)
    begin
        if (start)
            snap_reg <= cells;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (taken)
        begin
            if (cnt_reg == atau_pkg::LAST_IX)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign cell_valid       = busy_reg;
    assign cell_index       = cnt_reg;
    assign cell_value       = snap_reg[cnt_reg];
    assign last_cell        = (cnt_reg == atau_pkg::LAST_IX);
    assign status.busy      = busy_reg;
    assign status.finishing = taken && (cnt_reg == atau_pkg::LAST_IX);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for affine_transform_accumulator_unit: directed table, then random
// transform/read items with random idling on both channels, checked against a matrix tracker.
// Depends on rtl/atau_pkg.sv and rtl/affine_transform_accumulator_unit.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_SPARE = 3'd7;
    localparam atau_pkg::cell_t Q_MAX  = 32'sh7FFF_FFFF;
    localparam atau_pkg::cell_t Q_MIN  = 32'sh8000_0000;
    localparam atau_pkg::cell_t Q_ZERO = '0;

    typedef struct packed {
        logic [3:0]  ix;
        logic [31:0] val;
        logic        fin;
    } cell_rec_t;

    // typed rows: matrix known to be diagonal, diag packed as {cell15, cell10, cell5, cell0}
    typedef struct packed {
        logic [2:0]       op;
        atau_pkg::cell_t  a;
        atau_pkg::cell_t  b;
        atau_pkg::cell_t  c;
        logic             typed;
        logic [3:0][31:0] diag;
    } row_t;

    localparam int PLAN_LEN = 25;
    localparam row_t PLAN [PLAN_LEN] = '{
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b1,
          {atau_pkg::ONE, atau_pkg::ONE, atau_pkg::ONE, atau_pkg::ONE}},
        '{FUNC_SPARE,               Q_MAX,  Q_MIN,  -1,    1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b1,
          {atau_pkg::ONE, atau_pkg::ONE, atau_pkg::ONE, atau_pkg::ONE}},
        '{atau_pkg::FUNC_SCALE,     Q_MAX,  Q_MIN,  0,     1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b1,
          {atau_pkg::ONE, Q_ZERO, Q_MIN, Q_MAX}},
        '{atau_pkg::FUNC_SCALE,     Q_MAX,  Q_MAX,  Q_MAX, 1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b1,
          {atau_pkg::ONE, Q_ZERO, Q_MIN, Q_MAX}},
        '{atau_pkg::FUNC_SCALE,     Q_MIN,  Q_MIN,  Q_MIN, 1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b1,
          {atau_pkg::ONE, Q_ZERO, Q_MAX, Q_MIN}},
        '{atau_pkg::FUNC_IDENTITY,  Q_MAX,  Q_MIN,  1,     1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b1,
          {atau_pkg::ONE, atau_pkg::ONE, atau_pkg::ONE, atau_pkg::ONE}},
        '{atau_pkg::FUNC_TRANSLATE, 32'sd196608, -32'sd131072, 32'sd98304, 1'b0, '0},
        '{atau_pkg::FUNC_ROT_X,     32'sd46341, 32'sd46341, 32'hDEAD_BEEF, 1'b0, '0},
        '{atau_pkg::FUNC_ROT_Y,     0,      atau_pkg::ONE, 0, 1'b0, '0},
        '{atau_pkg::FUNC_ROT_Z,     32'sd56756, -32'sd32768, 0, 1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b0, '0},
        '{atau_pkg::FUNC_TRANSLATE, Q_MAX,  Q_MAX,  Q_MAX, 1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b0, '0},
        '{atau_pkg::FUNC_ROT_Z,     Q_MIN,  Q_MAX,  0,     1'b0, '0},
        '{atau_pkg::FUNC_TRANSLATE, Q_MIN,  Q_MIN,  Q_MIN, 1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b0, '0},
        '{atau_pkg::FUNC_SCALE,     -atau_pkg::ONE, atau_pkg::ONE, 1, 1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b0, '0},
        '{atau_pkg::FUNC_READ,      0,      0,      0,     1'b0, '0},
        '{atau_pkg::FUNC_IDENTITY,  0,      0,      0,     1'b0, '0}
    };

    logic            clk;
    logic            rst_n      = 1'b0;
    logic            cmd_valid  = 1'b0;
    logic            cmd_stall;
    logic [2:0]      func       = '0;
    atau_pkg::cell_t operand_a  = '0;
    atau_pkg::cell_t operand_b  = '0;
    atau_pkg::cell_t operand_c  = '0;
    logic            cell_valid;
    logic            cell_stall = 1'b0;
    logic [3:0]      cell_index;
    atau_pkg::cell_t cell_value;
    logic            last_cell;

    atau_pkg::cell_t mtx [atau_pkg::CELLS];
    cell_rec_t       cells_due [$];
    int              errors = 0;
    int unsigned     tx_left = 0;
    int unsigned     rx_left = 0;
    bit              tx_calm = 1'b0;
    bit              rx_calm = 1'b0;

    affine_transform_accumulator_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .func       (func),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .operand_c  (operand_c),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .last_cell  (last_cell)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint qmul(input longint x, input longint y);
        longint p;
        p = x * y;
        return p >>> atau_pkg::FRAC_BITS;
    endfunction

    function automatic atau_pkg::cell_t clamp32(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return atau_pkg::cell_t'(v);
    endfunction

    // col p' = cs*p + sn*q, col q' = cs*q - sn*p, from the old columns
    function automatic void spin(input int p, input int q, input atau_pkg::cell_t cs,
                                 input atau_pkg::cell_t sn);
        atau_pkg::cell_t vp;
        atau_pkg::cell_t vq;
        for (int r = 0; r < 4; r++)
        begin
            vp = mtx[p*4 + r];
            vq = mtx[q*4 + r];
            mtx[p*4 + r] = clamp32(qmul(cs, vp) + qmul(sn, vq));
            mtx[q*4 + r] = clamp32(qmul(cs, vq) - qmul(sn, vp));
        end
    endfunction

    function automatic void load_identity();
        for (int k = 0; k < atau_pkg::CELLS; k++)
            mtx[k] = (k % 5 == 0) ? atau_pkg::ONE : Q_ZERO;
    endfunction

    function automatic void track_matrix(input logic [2:0] op, input atau_pkg::cell_t a,
                                         input atau_pkg::cell_t b, input atau_pkg::cell_t c,
                                         input bit emit);
        cell_rec_t rec;
        case (op)
            atau_pkg::FUNC_IDENTITY:
                load_identity();
            atau_pkg::FUNC_TRANSLATE:
                for (int r = 0; r < 4; r++)
                    mtx[12 + r] = clamp32(qmul(a, mtx[r]) + qmul(b, mtx[4 + r])
                                          + qmul(c, mtx[8 + r]) + longint'(mtx[12 + r]));
            atau_pkg::FUNC_SCALE:
                for (int r = 0; r < 4; r++)
                begin
                    mtx[r]     = clamp32(qmul(a, mtx[r]));
                    mtx[4 + r] = clamp32(qmul(b, mtx[4 + r]));
                    mtx[8 + r] = clamp32(qmul(c, mtx[8 + r]));
                end
            atau_pkg::FUNC_ROT_X:
                spin(1, 2, a, b);
            atau_pkg::FUNC_ROT_Y:
                spin(2, 0, a, b);
            atau_pkg::FUNC_ROT_Z:
                spin(0, 1, a, b);
            atau_pkg::FUNC_READ:
                if (emit)
                    for (int k = 0; k < atau_pkg::CELLS; k++)
                    begin
                        rec.ix  = k[3:0];
                        rec.val = mtx[k];
                        rec.fin = (k == atau_pkg::CELLS - 1);
                        cells_due.push_back(rec);
                    end
            default: ;
        endcase
    endfunction

    function automatic int unsigned pick_wait(inout int unsigned left, inout bit calm);
        if (left == 0)
        begin
            left = $urandom_range(8, 40);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic atau_pkg::cell_t rand_q(input int span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return atau_pkg::cell_t'($urandom);
        if (pick < 35)
            case ($urandom_range(0, 4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return Q_ZERO;
                3: return atau_pkg::ONE;
                default: return -atau_pkg::ONE;
            endcase
        return atau_pkg::cell_t'(int'($urandom_range(0, 2*span)) - span);
    endfunction

    task automatic issue(input logic [2:0] op, input atau_pkg::cell_t a,
                         input atau_pkg::cell_t b, input atau_pkg::cell_t c);
        int unsigned gap;
        gap = pick_wait(tx_left, tx_calm);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        func      <= op;
        operand_a <= a;
        operand_b <= b;
        operand_c <= c;
        do @(posedge clk); while (cmd_stall);
    endtask

    initial
    begin : rx_side
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = pick_wait(rx_left, rx_calm);
            if (hold != 0)
            begin
                cell_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            cell_stall <= 1'b0;
            do @(posedge clk); while (!cell_valid);
        end
    end

    always @(posedge clk)
    begin : cell_check
        cell_rec_t want;
        if (rst_n && cell_valid && !cell_stall)
        begin
            if (cells_due.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got index %0d value %h last %b",
                         $time, cell_index, cell_value, last_cell);
                errors++;
            end
            else
            begin
                want = cells_due.pop_front();
                if (cell_index !== want.ix)
                begin
                    $display("%0t: cell_index expected %0d got %0d", $time, want.ix, cell_index);
                    errors++;
                end
                if (cell_value !== want.val)
                begin
                    $display("%0t: cell_value (cell %0d) expected %h got %h",
                             $time, want.ix, want.val, cell_value);
                    errors++;
                end
                if (last_cell !== want.fin)
                begin
                    $display("%0t: last_cell (cell %0d) expected %b got %b",
                             $time, want.ix, want.fin, last_cell);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        cell_rec_t       rec;
        logic [2:0]      op;
        atau_pkg::cell_t a;
        atau_pkg::cell_t b;
        atau_pkg::cell_t c;
        int unsigned     w;
        real             ang;

        load_identity();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            issue(PLAN[i].op, PLAN[i].a, PLAN[i].b, PLAN[i].c);
            track_matrix(PLAN[i].op, PLAN[i].a, PLAN[i].b, PLAN[i].c, !PLAN[i].typed);
            if (PLAN[i].typed)
                for (int k = 0; k < atau_pkg::CELLS; k++)
                begin
                    rec.ix  = k[3:0];
                    rec.val = (k % 5 == 0) ? PLAN[i].diag[k/5] : 32'h0;
                    rec.fin = (k == atau_pkg::CELLS - 1);
                    cells_due.push_back(rec);
                end
        end

        // drain fully before the random part
        cmd_valid <= 1'b0;
        do @(posedge clk); while (cells_due.size() != 0);

        for (int n = 0; n < 500; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 6)
                op = atau_pkg::FUNC_IDENTITY;
            else if (w < 26)
                op = atau_pkg::FUNC_TRANSLATE;
            else if (w < 40)
                op = atau_pkg::FUNC_SCALE;
            else if (w < 73)
                op = (w < 51) ? atau_pkg::FUNC_ROT_X
                   : (w < 62) ? atau_pkg::FUNC_ROT_Y : atau_pkg::FUNC_ROT_Z;
            else if (w < 93)
                op = atau_pkg::FUNC_READ;
            else
                op = FUNC_SPARE;

            if (op == atau_pkg::FUNC_SCALE)
            begin
                a = rand_q(2*atau_pkg::ONE);
                b = rand_q(2*atau_pkg::ONE);
                c = rand_q(2*atau_pkg::ONE);
            end
            else
            begin
                a = rand_q(16*atau_pkg::ONE);
                b = rand_q(16*atau_pkg::ONE);
                c = rand_q(16*atau_pkg::ONE);
            end
            if ((op == atau_pkg::FUNC_ROT_X || op == atau_pkg::FUNC_ROT_Y
                 || op == atau_pkg::FUNC_ROT_Z) && $urandom_range(0, 9) < 7)
            begin
                ang = real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
                a = atau_pkg::cell_t'($rtoi($cos(ang) * 65536.0));
                b = atau_pkg::cell_t'($rtoi($sin(ang) * 65536.0));
            end

            issue(op, a, b, c);
            track_matrix(op, a, b, c, 1'b1);
        end

        cmd_valid <= 1'b0;
        do @(posedge clk); while (cells_due.size() != 0);
        repeat (40) @(posedge clk);

        if (errors == 0 && cells_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
